@@ hw/rtl/dbsd_pkg.sv @@
// Shared types, constants and table functions for the dual bridge stepper drive.
// No dependencies; used by the speed mapper and the drive core.
`default_nettype none

package dbsd_pkg;

	// clamped speed, -100..100
	typedef logic signed [7:0] speed_t;

	typedef struct packed {
		speed_t a;
		speed_t b;
	} speed_pair_t;

	localparam logic REQ_SPEED = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	localparam logic MODE_SIGN_MAG = 1'b0;
	localparam logic MODE_LAP      = 1'b1;

	localparam logic [1:0] STYLE_WAVE = 2'd0;
	localparam logic [1:0] STYLE_FULL = 2'd1;
	localparam logic [1:0] STYLE_HALF = 2'd2;

	localparam logic [3:0] PHASE_FIRST     = 4'd1;
	localparam logic [3:0] PHASE_LAST_QUAD = 4'd4;
	localparam logic [3:0] PHASE_LAST_HALF = 4'd8;

	localparam speed_t SPD_POS  = 8'sd100;
	localparam speed_t SPD_NEG  = -8'sd100;
	localparam speed_t SPD_ZERO = 8'sd0;

	function automatic speed_t clamp_speed(input logic signed [15:0] s);
		speed_t r;
		if (s > 16'sd100) begin
			r = SPD_POS;
		end else if (s < -16'sd100) begin
			r = SPD_NEG;
		end else begin
			r = s[7:0];
		end
		return r;
	endfunction

	// Speed pair of a phase; idx is phase - 1. Unused style gives zeros.
	function automatic speed_pair_t phase_speeds(input logic [1:0] style,
		input logic [2:0] idx);
		speed_pair_t r;
		r = '{a: SPD_ZERO, b: SPD_ZERO};
		unique case (style)
			STYLE_WAVE: begin
				unique case (idx[1:0])
					2'd0: r = '{a: SPD_POS,  b: SPD_ZERO};
					2'd1: r = '{a: SPD_ZERO, b: SPD_POS};
					2'd2: r = '{a: SPD_NEG,  b: SPD_ZERO};
					default: r = '{a: SPD_ZERO, b: SPD_NEG};
				endcase
			end
			STYLE_FULL: begin
				unique case (idx[1:0])
					2'd0: r = '{a: SPD_POS, b: SPD_POS};
					2'd1: r = '{a: SPD_NEG, b: SPD_POS};
					2'd2: r = '{a: SPD_NEG, b: SPD_NEG};
					default: r = '{a: SPD_POS, b: SPD_NEG};
				endcase
			end
			STYLE_HALF: begin
				unique case (idx)
					3'd0: r = '{a: SPD_POS,  b: SPD_ZERO};
					3'd1: r = '{a: SPD_POS,  b: SPD_POS};
					3'd2: r = '{a: SPD_ZERO, b: SPD_POS};
					3'd3: r = '{a: SPD_NEG,  b: SPD_POS};
					3'd4: r = '{a: SPD_NEG,  b: SPD_ZERO};
					3'd5: r = '{a: SPD_NEG,  b: SPD_NEG};
					3'd6: r = '{a: SPD_ZERO, b: SPD_NEG};
					default: r = '{a: SPD_POS, b: SPD_NEG};
				endcase
			end
			default: r = '{a: SPD_ZERO, b: SPD_ZERO};
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dbsd_if.sv @@
// Valid/ready channel interfaces for command beats in and drive beats out.
// Standalone; payload widths follow the block's field list.
`default_nettype none

interface dbsd_in_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [15:0] speed_a;
	logic signed [15:0] speed_b;
	logic        [1:0]  step_style;
	logic               clockwise;

	modport source (output valid, output req_type, output speed_a, output speed_b,
		output step_style, output clockwise, input ready);
	modport sink (input valid, input req_type, input speed_a, input speed_b,
		input step_style, input clockwise, output ready);
endinterface

interface dbsd_out_if;
	logic       valid;
	logic       ready;
	logic [9:0] duty_a;
	logic       dir_a;
	logic [9:0] duty_b;
	logic       dir_b;

	modport source (output valid, output duty_a, output dir_a, output duty_b,
		output dir_b, input ready);
	modport sink (input valid, input duty_a, input dir_a, input duty_b,
		input dir_b, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dual_bridge_stepper_drive_core.sv @@
// Dual H-bridge drive: speed commands and stepper phase steps to duty/direction.
// Input beats pass through stage 1 and stage 2 to the output; one beat per cycle sustained while the sink is ready.
// Stage 1 registers the clamped or table speeds, stage 2 the mapped result;
// throughput is set by the phase register update at input accept.
// Reset (arst_n low, async): phase to 1, mode to signed magnitude, pipe empty.
// Depends on dbsd_pkg, dbsd_if (channel interfaces) and dbsd_speed_map.
`default_nettype none

module dual_bridge_stepper_drive_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	dbsd_in_if.sink     in_ch,
	dbsd_out_if.source  out_ch
);

	// config: drive_mode register
	logic drive_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_mode_q <= dbsd_pkg::MODE_SIGN_MAG;
		end else if (cfg_we) begin
			drive_mode_q <= cfg_wdata;
		end
	end

	// pipeline handshake: each stage loads when empty or when downstream drains
	logic valid_s1, valid_s2;
	logic en_s1, en_s2;
	logic in_acc;

	assign en_s2       = !valid_s2 || out_ch.ready;
	assign en_s1       = !valid_s1 || en_s2;
	assign in_ch.ready = en_s1;
	assign in_acc      = in_ch.valid && en_s1;

	// phase stepping, evaluated on the incoming beat
	logic [3:0]            step_phase_q;
	logic [3:0]            last_phase;
	logic                  style_ok;
	logic                  phase_ok;
	logic [3:0]            phase_m1;
	logic [3:0]            phase_nxt;
	dbsd_pkg::speed_pair_t tab_pair;
	logic                  step_emit;
	logic                  emit;
	dbsd_pkg::speed_t      sa_in, sb_in;

	always_comb begin
		last_phase = (in_ch.step_style == dbsd_pkg::STYLE_HALF) ?
			dbsd_pkg::PHASE_LAST_HALF : dbsd_pkg::PHASE_LAST_QUAD;
		style_ok   = (in_ch.step_style == dbsd_pkg::STYLE_WAVE) ||
			(in_ch.step_style == dbsd_pkg::STYLE_FULL) ||
			(in_ch.step_style == dbsd_pkg::STYLE_HALF);
		phase_ok   = style_ok && (step_phase_q >= dbsd_pkg::PHASE_FIRST) &&
			(step_phase_q <= last_phase);
		phase_m1   = step_phase_q - 4'd1;
		tab_pair   = dbsd_pkg::phase_speeds(in_ch.step_style, phase_m1[2:0]);

		if (in_ch.clockwise) begin
			phase_nxt = (step_phase_q == last_phase) ? dbsd_pkg::PHASE_FIRST
				: step_phase_q + 4'd1;
		end else begin
			phase_nxt = (step_phase_q == dbsd_pkg::PHASE_FIRST) ? last_phase
				: phase_m1;
		end

		step_emit = (in_ch.req_type == dbsd_pkg::REQ_STEP) && phase_ok;
		emit      = (in_ch.req_type == dbsd_pkg::REQ_SPEED) || phase_ok;

		if (in_ch.req_type == dbsd_pkg::REQ_SPEED) begin
			sa_in = dbsd_pkg::clamp_speed(in_ch.speed_a);
			sb_in = dbsd_pkg::clamp_speed(in_ch.speed_b);
		end else begin
			sa_in = tab_pair.a;
			sb_in = tab_pair.b;
		end
	end

	// phase only moves on an accepted step beat that lands inside the style's range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_phase_q <= dbsd_pkg::PHASE_FIRST;
		end else if (in_acc && step_emit) begin
			step_phase_q <= phase_nxt;
		end
	end

	// stage 1: clamped or table speed pair; beats with no result leave a bubble
	dbsd_pkg::speed_t sa_s1, sb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sa_s1 <= sa_in;
			sb_s1 <= sb_in;
		end
	end

	// mapping to duty/direction for both channels
	logic [9:0] duty_a_m, duty_b_m;
	logic       dir_a_m, dir_b_m;

	dbsd_speed_map u_map_a (
		.drive_mode (drive_mode_q),
		.speed      (sa_s1),
		.duty       (duty_a_m),
		.dir        (dir_a_m)
	);

	dbsd_speed_map u_map_b (
		.drive_mode (drive_mode_q),
		.speed      (sb_s1),
		.duty       (duty_b_m),
		.dir        (dir_b_m)
	);

	// stage 2: output register, holds while the sink stalls
	logic [9:0] duty_a_s2, duty_b_s2;
	logic       dir_a_s2, dir_b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			duty_a_s2 <= duty_a_m;
			dir_a_s2  <= dir_a_m;
			duty_b_s2 <= duty_b_m;
			dir_b_s2  <= dir_b_m;
		end
	end

	assign out_ch.valid  = valid_s2;
	assign out_ch.duty_a = duty_a_s2;
	assign out_ch.dir_a  = dir_a_s2;
	assign out_ch.duty_b = duty_b_s2;
	assign out_ch.dir_b  = dir_b_s2;

endmodule

`default_nettype wire

@@ hw/rtl/dbsd_speed_map.sv @@
// Maps one clamped speed to a 10-bit duty and a direction level.
// Depends on dbsd_pkg.
`default_nettype none

module dbsd_speed_map (
	input  wire logic             drive_mode,
	input  wire dbsd_pkg::speed_t speed,
	output logic [9:0]            duty,
	output logic                  dir
);

	logic [7:0]         neg;
	logic [9:0]         mag;
	logic [9:0]         duty_sm;
	logic signed [10:0] sx;
	logic signed [10:0] duty_lap;

	always_comb begin
		neg      = 8'(-speed);
		mag      = speed[7] ? {3'b000, neg[6:0]} : {3'b000, speed[6:0]};
		duty_sm  = (mag << 3) + (mag << 1);              // 10 * |s|
		sx       = {{3{speed[7]}}, speed};
		duty_lap = 11'sd511 - ((sx <<< 2) + sx);         // 511 - 5 * s
		unique case (drive_mode)
			dbsd_pkg::MODE_SIGN_MAG: begin
				duty = duty_sm;
				dir  = speed[7];
			end
			default: begin
				duty = duty_lap[9:0];
				dir  = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire
